>>> rtl/core/smfe_pkg.sv
// ----------------------------------------------------------------------------
// smfe_pkg
// Shared types, widths and helpers of the string copy and fill engine.
// ----------------------------------------------------------------------------
package smfe_pkg;

  // default sizes, handed down from the top level
  localparam int unsigned MEM_BYTES_DEF = 4096;
  localparam int unsigned MAX_COUNT_DEF = 4096;

  // fixed field widths
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned SIZE_W   = 4;
  localparam int unsigned MADDR_W  = 12;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LANE_W   = 3;

  // instruction codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_COPY  = 2'd2,
    CMD_FILL  = 2'd3
  } cmd_e;

  // completion codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_SIZE  = 2'd1,
    ST_COUNT_OVF = 2'd2
  } status_e;

  // one result transaction
  typedef struct packed {
    status_e             status;
    logic [WORD_W-1:0]   src_out;
    logic [WORD_W-1:0]   dst_out;
    logic [WORD_W-1:0]   count_out;
    logic [BYTE_W-1:0]   read_data;
  } result_t;

  // element sizes the engine supports
  function automatic logic size_valid(logic [SIZE_W-1:0] size);
    return (size inside {4'd1, 4'd2, 4'd4, 4'd8});
  endfunction

  // accumulator mask for an element size
  function automatic logic [WORD_W-1:0] elem_mask(logic [SIZE_W-1:0] size);
    logic [WORD_W-1:0] m;
    case (size)
      4'd1:    m = 64'h0000_0000_0000_00FF;
      4'd2:    m = 64'h0000_0000_0000_FFFF;
      4'd4:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/smfe_req_if.sv
// ----------------------------------------------------------------------------
// smfe_req_if
// Instruction channel: valid/ready handshake and the instruction fields.
// ----------------------------------------------------------------------------
interface smfe_req_if;
  logic                              valid;
  logic                              ready;
  logic [smfe_pkg::CMD_W-1:0]        cmd;
  logic                              repeat_on;
  logic                              dir_down;
  logic [smfe_pkg::SIZE_W-1:0]       elem_bytes;
  logic [smfe_pkg::WORD_W-1:0]       count_in;
  logic [smfe_pkg::WORD_W-1:0]       src_ptr;
  logic [smfe_pkg::WORD_W-1:0]       dst_ptr;
  logic [smfe_pkg::WORD_W-1:0]       fill_value;
  logic [smfe_pkg::MADDR_W-1:0]      mem_addr;
  logic [smfe_pkg::BYTE_W-1:0]       mem_data;

  modport source (
    output valid, cmd, repeat_on, dir_down, elem_bytes, count_in, src_ptr, dst_ptr,
           fill_value, mem_addr, mem_data,
    input  ready
  );

  modport sink (
    input  valid, cmd, repeat_on, dir_down, elem_bytes, count_in, src_ptr, dst_ptr,
           fill_value, mem_addr, mem_data,
    output ready
  );
endinterface

>>> rtl/core/smfe_rsp_if.sv
// ----------------------------------------------------------------------------
// smfe_rsp_if
// Result channel: valid/ready handshake and the result fields.
// ----------------------------------------------------------------------------
interface smfe_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [smfe_pkg::STATUS_W-1:0]     status;
  logic [smfe_pkg::WORD_W-1:0]       src_out;
  logic [smfe_pkg::WORD_W-1:0]       dst_out;
  logic [smfe_pkg::WORD_W-1:0]       count_out;
  logic [smfe_pkg::BYTE_W-1:0]       read_data;

  modport source (
    output valid, status, src_out, dst_out, count_out, read_data,
    input  ready
  );

  modport sink (
    input  valid, status, src_out, dst_out, count_out, read_data,
    output ready
  );
endinterface

>>> rtl/core/smfe_mem.sv
// ----------------------------------------------------------------------------
// smfe_mem
// Byte-wide single-port-write, single-port-read memory, registered read.
// ----------------------------------------------------------------------------
module smfe_mem #(
  parameter int unsigned MEM_BYTES = smfe_pkg::MEM_BYTES_DEF,
  localparam int unsigned AW       = $clog2(MEM_BYTES)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [smfe_pkg::BYTE_W-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [smfe_pkg::BYTE_W-1:0] rdata_o
);

  logic [smfe_pkg::BYTE_W-1:0] mem_q [MEM_BYTES];
  logic [smfe_pkg::BYTE_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/smfe_seq.sv
// ----------------------------------------------------------------------------
// smfe_seq
// Instruction sequencer: checks the instruction, walks the elements byte by
// byte through the memory and tracks the pointers and the remaining count.
// ----------------------------------------------------------------------------
module smfe_seq #(
  parameter int unsigned MEM_BYTES = smfe_pkg::MEM_BYTES_DEF,
  parameter int unsigned MAX_COUNT = smfe_pkg::MAX_COUNT_DEF,
  localparam int unsigned AW       = $clog2(MEM_BYTES),
  localparam int unsigned CW       = $clog2(MAX_COUNT + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  smfe_req_if.sink                    req_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output smfe_pkg::result_t           res_o,
  output logic                        mem_we_o,
  output logic [AW-1:0]               mem_waddr_o,
  output logic [smfe_pkg::BYTE_W-1:0] mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AW-1:0]               mem_raddr_o,
  input  logic [smfe_pkg::BYTE_W-1:0] mem_rdata_i
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b000_0001,
    S_CHECK  = 7'b000_0010,
    S_RDWAIT = 7'b000_0100,
    S_LOAD   = 7'b000_1000,
    S_LWAIT  = 7'b001_0000,
    S_STORE  = 7'b010_0000,
    S_DONE   = 7'b100_0000
  } state_e;

  state_e                        state_q, state_d;
  smfe_pkg::cmd_e                cmd_q;
  logic                          rep_q;
  logic                          down_q;
  logic [smfe_pkg::SIZE_W-1:0]   size_q;
  logic [smfe_pkg::WORD_W-1:0]   count_in_q;
  logic [smfe_pkg::WORD_W-1:0]   src_q;
  logic [smfe_pkg::WORD_W-1:0]   dst_q;
  logic [smfe_pkg::WORD_W-1:0]   fill_q;
  logic [AW-1:0]                 maddr_q;
  logic [smfe_pkg::BYTE_W-1:0]   mdata_q;
  logic [smfe_pkg::WORD_W-1:0]   buf_q;
  logic [smfe_pkg::LANE_W-1:0]   lane_q;
  logic [smfe_pkg::LANE_W-1:0]   rd_lane_q;
  logic                          rd_pend_q;
  logic [CW-1:0]                 rem_q;
  smfe_pkg::status_e             status_q;
  logic [smfe_pkg::BYTE_W-1:0]   rdata_q;
  logic                          exec_q;

  logic                          req_fire;
  logic [smfe_pkg::WORD_W-1:0]   cnt;
  logic                          cnt_zero;
  logic                          cnt_big;
  logic                          size_ok;
  logic                          lane_last;
  logic [smfe_pkg::WORD_W-1:0]   step;
  logic [smfe_pkg::WORD_W-1:0]   src_nxt;
  logic [smfe_pkg::WORD_W-1:0]   dst_nxt;
  logic [AW-1:0]                 src_byte_addr;
  logic [AW-1:0]                 dst_byte_addr;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;

  // instruction checks
  assign cnt      = rep_q ? count_in_q : smfe_pkg::WORD_W'(1);
  assign cnt_zero = (cnt == '0);
  assign cnt_big  = (cnt > smfe_pkg::WORD_W'(MAX_COUNT));
  assign size_ok  = smfe_pkg::size_valid(size_q);

  // element walk
  assign lane_last     = (lane_q == smfe_pkg::LANE_W'(size_q - 4'd1));
  assign step          = smfe_pkg::WORD_W'(size_q);
  assign src_nxt       = down_q ? (src_q - step) : (src_q + step);
  assign dst_nxt       = down_q ? (dst_q - step) : (dst_q + step);
  assign src_byte_addr = src_q[AW-1:0] + AW'(lane_q);
  assign dst_byte_addr = dst_q[AW-1:0] + AW'(lane_q);

  // next state and memory requests
  always_comb begin
    state_d     = state_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_waddr_o = dst_byte_addr;
    mem_wdata_o = buf_q[lane_q*smfe_pkg::BYTE_W +: smfe_pkg::BYTE_W];
    mem_raddr_o = src_byte_addr;
    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        case (cmd_q)
          smfe_pkg::CMD_WRITE: begin
            mem_we_o    = 1'b1;
            mem_waddr_o = maddr_q;
            mem_wdata_o = mdata_q;
            state_d     = S_DONE;
          end
          smfe_pkg::CMD_READ: begin
            mem_re_o    = 1'b1;
            mem_raddr_o = maddr_q;
            state_d     = S_RDWAIT;
          end
          default: begin
            if (cnt_zero || !size_ok || cnt_big) begin
              state_d = S_DONE;
            end else if (cmd_q == smfe_pkg::CMD_COPY) begin
              state_d = S_LOAD;
            end else begin
              state_d = S_STORE;
            end
          end
        endcase
      end
      S_RDWAIT: begin
        state_d = S_DONE;
      end
      S_LOAD: begin
        mem_re_o = 1'b1;
        if (lane_last) begin
          state_d = S_LWAIT;
        end
      end
      S_LWAIT: begin
        state_d = S_STORE;
      end
      S_STORE: begin
        mem_we_o = 1'b1;
        if (lane_last) begin
          if (rem_q == CW'(1)) begin
            state_d = S_DONE;
          end else if (cmd_q == smfe_pkg::CMD_COPY) begin
            state_d = S_LOAD;
          end else begin
            state_d = S_STORE;
          end
        end
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == S_LOAD);
    end
  end

  // instruction fields, pointers, element buffer and result values
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      cmd_q      <= smfe_pkg::cmd_e'(req_i.cmd);
      rep_q      <= req_i.repeat_on;
      down_q     <= req_i.dir_down;
      size_q     <= req_i.elem_bytes;
      count_in_q <= req_i.count_in;
      src_q      <= req_i.src_ptr;
      dst_q      <= req_i.dst_ptr;
      fill_q     <= req_i.fill_value;
      maddr_q    <= AW'(smfe_pkg::WORD_W'(req_i.mem_addr));
      mdata_q    <= req_i.mem_data;
    end

    if (state_q == S_CHECK) begin
      rem_q   <= cnt[CW-1:0];
      lane_q  <= '0;
      rdata_q <= '0;
      exec_q  <= 1'b0;
      if (cmd_q == smfe_pkg::CMD_COPY || cmd_q == smfe_pkg::CMD_FILL) begin
        if (cnt_zero) begin
          status_q <= smfe_pkg::ST_OK;
        end else if (!size_ok) begin
          status_q <= smfe_pkg::ST_BAD_SIZE;
        end else if (cnt_big) begin
          status_q <= smfe_pkg::ST_COUNT_OVF;
        end else begin
          status_q <= smfe_pkg::ST_OK;
          exec_q   <= 1'b1;
        end
      end else begin
        status_q <= smfe_pkg::ST_OK;
      end
      if (cmd_q == smfe_pkg::CMD_FILL) begin
        buf_q <= fill_q & smfe_pkg::elem_mask(size_q);
      end
    end

    // read data of a byte read
    if (state_q == S_RDWAIT) begin
      rdata_q <= mem_rdata_i;
    end

    // gather source element bytes as they return
    if (rd_pend_q) begin
      buf_q[rd_lane_q*smfe_pkg::BYTE_W +: smfe_pkg::BYTE_W] <= mem_rdata_i;
    end

    if (state_q == S_LOAD) begin
      rd_lane_q <= lane_q;
      lane_q    <= lane_last ? '0 : lane_q + 3'd1;
    end

    // element written out: advance pointers and count
    if (state_q == S_STORE) begin
      lane_q <= lane_last ? '0 : lane_q + 3'd1;
      if (lane_last) begin
        rem_q <= rem_q - CW'(1);
        dst_q <= dst_nxt;
        if (cmd_q == smfe_pkg::CMD_COPY) begin
          src_q <= src_nxt;
        end
      end
    end
  end

  // result
  assign res_valid_o     = (state_q == S_DONE);
  assign res_o.status    = status_q;
  assign res_o.src_out   = src_q;
  assign res_o.dst_out   = dst_q;
  assign res_o.count_out = (exec_q && rep_q) ? '0 : count_in_q;
  assign res_o.read_data = rdata_q;

  // checks
  a_no_rw_same_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we_o && mem_re_o))
    else $error("memory read and write issued together");

  a_rem_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD || state_q == S_STORE) |-> (rem_q != '0))
    else $error("element walk with no elements left");

  a_rd_pend_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> (state_q == S_LOAD || state_q == S_LWAIT))
    else $error("source byte returned outside the load phase");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && !res_ready_i) |=> (state_q == S_DONE))
    else $error("result dropped before hand-off");

endmodule

>>> rtl/core/string_move_fill_engine_core.sv
// One instruction is in flight at a time; the single byte-wide memory port sets
// the rate (at most one byte read or written per cycle). The next instruction
// is accepted while a finished result still waits in the output register.
// Reset clears the control state only; the byte memory is undefined until written.
// ----------------------------------------------------------------------------
// string_move_fill_engine_core
// String copy and fill engine over an internal byte memory, with an output
// register on the result channel.
// ----------------------------------------------------------------------------
module string_move_fill_engine_core #(
  parameter int unsigned MEM_BYTES = smfe_pkg::MEM_BYTES_DEF,
  parameter int unsigned MAX_COUNT = smfe_pkg::MAX_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smfe_req_if.sink    req_i,
  smfe_rsp_if.source  rsp_o
);

  localparam int unsigned AW = $clog2(MEM_BYTES);

  logic                        res_valid;
  logic                        res_ready;
  smfe_pkg::result_t           res;
  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [smfe_pkg::BYTE_W-1:0] mem_wdata;
  logic                        mem_re;
  logic [AW-1:0]               mem_raddr;
  logic [smfe_pkg::BYTE_W-1:0] mem_rdata;
  logic                        out_valid_q;
  smfe_pkg::result_t           out_q;

  smfe_seq #(
    .MEM_BYTES (MEM_BYTES),
    .MAX_COUNT (MAX_COUNT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  smfe_mem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register slot is free when empty or being drained
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_q.status;
  assign rsp_o.src_out   = out_q.src_out;
  assign rsp_o.dst_out   = out_q.dst_out;
  assign rsp_o.count_out = out_q.count_out;
  assign rsp_o.read_data = out_q.read_data;

endmodule

>>> dv/smfe_string_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// smfe_string_checker
// Watches the instruction and result channels of the string copy and fill
// engine, keeps its own copy of the byte memory, predicts each result and
// compares it field by field with what the engine returns.
// ----------------------------------------------------------------------------
module smfe_string_checker #(
  parameter int unsigned MEM_BYTES = smfe_pkg::MEM_BYTES_DEF,
  parameter int unsigned MAX_COUNT = smfe_pkg::MAX_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  smfe_req_if         req,
  smfe_rsp_if         rsp,
  output int unsigned pending_o,
  output int unsigned fail_cnt_o
);

  // shadow of the engine's byte memory
  logic [7:0]        shadow_mem [MEM_BYTES];
  smfe_pkg::result_t expected_results [$];
  int unsigned       pending_cnt = 0;
  int unsigned       fail_cnt    = 0;

  assign pending_o  = pending_cnt;
  assign fail_cnt_o = fail_cnt;

  function automatic int unsigned mem_index(input logic [63:0] addr);
    return 32'(addr % 64'(MEM_BYTES));
  endfunction

  // carry out one instruction on the shadow memory and build its result
  task automatic execute_string_op(
    input  smfe_pkg::cmd_e    op,
    input  logic              rep,
    input  logic              down,
    input  logic [3:0]        size,
    input  logic [63:0]       cnt_in,
    input  logic [63:0]       src,
    input  logic [63:0]       dst,
    input  logic [63:0]       fill_v,
    input  logic [11:0]       maddr,
    input  logic [7:0]        mdata,
    output smfe_pkg::result_t res
  );
    logic [63:0] n_elems;
    logic [63:0] stride;
    logic [63:0] mask;
    logic [63:0] elem;
    logic [63:0] sp;
    logic [63:0] dp;
    logic [63:0] k;
    int unsigned b;
    res.status    = smfe_pkg::ST_OK;
    res.src_out   = src;
    res.dst_out   = dst;
    res.count_out = cnt_in;
    res.read_data = '0;
    case (op)
      smfe_pkg::CMD_WRITE: shadow_mem[mem_index(64'(maddr))] = mdata;
      smfe_pkg::CMD_READ:  res.read_data = shadow_mem[mem_index(64'(maddr))];
      default: begin
        n_elems = rep ? cnt_in : 64'd1;
        // zero count wins over a bad size, a bad size over a large count
        if (n_elems == 64'd0) begin
          res.status = smfe_pkg::ST_OK;
        end else if (!(size == 4'd1 || size == 4'd2 || size == 4'd4 || size == 4'd8)) begin
          res.status = smfe_pkg::ST_BAD_SIZE;
        end else if (n_elems > 64'(MAX_COUNT)) begin
          res.status = smfe_pkg::ST_COUNT_OVF;
        end else begin
          stride = down ? (64'd0 - 64'(size)) : 64'(size);
          mask   = (size == 4'd8) ? '1 : ((64'd1 << (8 * size)) - 64'd1);
          sp     = src;
          dp     = dst;
          // element by element in walk order, each read whole before it is stored
          for (k = 64'd0; k < n_elems; k++) begin
            if (op == smfe_pkg::CMD_COPY) begin
              elem = '0;
              for (b = 0; b < size; b++)
                elem |= 64'(shadow_mem[mem_index(sp + 64'(b))]) << (8 * b);
            end else begin
              elem = fill_v & mask;
            end
            for (b = 0; b < size; b++)
              shadow_mem[mem_index(dp + 64'(b))] = elem[8*b +: 8];
            sp += stride;
            dp += stride;
          end
          if (op == smfe_pkg::CMD_COPY) res.src_out = sp;
          res.dst_out   = dp;
          res.count_out = rep ? 64'd0 : cnt_in;
        end
      end
    endcase
  endtask

  function automatic bit field_differs(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // compare finished results, then predict newly accepted instructions
  always @(posedge clk_i) begin
    smfe_pkg::result_t want;
    smfe_pkg::result_t predicted;
    bit                bad;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no instruction outstanding");
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          pending_cnt--;
          bad = 1'b0;
          bad |= field_differs("status", 64'(want.status), 64'(rsp.status));
          bad |= field_differs("src_out", want.src_out, rsp.src_out);
          bad |= field_differs("dst_out", want.dst_out, rsp.dst_out);
          bad |= field_differs("count_out", want.count_out, rsp.count_out);
          bad |= field_differs("read_data", 64'(want.read_data), 64'(rsp.read_data));
          if (bad) fail_cnt++;
        end
      end
      if (req.valid && req.ready) begin
        execute_string_op(smfe_pkg::cmd_e'(req.cmd), req.repeat_on, req.dir_down,
                          req.elem_bytes, req.count_in, req.src_ptr, req.dst_ptr,
                          req.fill_value, req.mem_addr, req.mem_data, predicted);
        expected_results.push_back(predicted);
        pending_cnt++;
      end
    end
  end

endmodule

>>> dv/tb_string_move_fill_engine_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_string_move_fill_engine_core
// Drives string copy, string fill and byte access instructions into the
// engine: a directed set of corner cases, then random traffic in bursts
// against a receiver that stalls, with one long result hold-off and one
// drain pause. The checker beside the engine predicts and compares.
// ----------------------------------------------------------------------------
module tb_string_move_fill_engine_core;

  localparam int unsigned MAX_CNT     = smfe_pkg::MAX_COUNT_DEF;
  localparam int unsigned RAND_INSTRS = 750;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  typedef struct {
    smfe_pkg::cmd_e op;
    logic           rep;
    logic           down;
    logic [3:0]     size;
    logic [63:0]    cnt;
    logic [63:0]    src;
    logic [63:0]    dst;
    logic [63:0]    fill_v;
    logic [11:0]    maddr;
    logic [7:0]     mdata;
  } instr_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned fail_cnt;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  bit          no_gaps = 1'b0;
  bit          hold_off_go = 1'b0;
  instr_t      directed_q [$];

  smfe_req_if req_if ();
  smfe_rsp_if rsp_if ();

  string_move_fill_engine_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  smfe_string_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_if),
    .rsp        (rsp_if),
    .pending_o  (pending),
    .fail_cnt_o (fail_cnt)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("string_move_fill_engine_core test failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic instr_t make_instr(
    input smfe_pkg::cmd_e op, input logic rep, input logic down, input logic [3:0] size,
    input logic [63:0] cnt, input logic [63:0] src, input logic [63:0] dst,
    input logic [63:0] fill_v, input logic [11:0] maddr, input logic [7:0] mdata
  );
    instr_t it;
    it.op = op;   it.rep = rep;       it.down = down;     it.size = size;
    it.cnt = cnt; it.src = src;       it.dst = dst;       it.fill_v = fill_v;
    it.maddr = maddr;                 it.mdata = mdata;
    return it;
  endfunction

  // mostly well-formed string instructions with short counts
  function automatic instr_t random_instr();
    instr_t      it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 15)      it.op = smfe_pkg::CMD_WRITE;
    else if (pick < 30) it.op = smfe_pkg::CMD_READ;
    else if (pick < 68) it.op = smfe_pkg::CMD_COPY;
    else                it.op = smfe_pkg::CMD_FILL;
    it.rep    = ($urandom_range(0, 4) != 0);
    it.down   = 1'($urandom_range(0, 1));
    it.size   = ($urandom_range(0, 9) != 0) ? (4'd1 << $urandom_range(0, 3))
                                            : 4'($urandom_range(0, 15));
    it.src    = rand64();
    it.dst    = rand64();
    it.fill_v = rand64();
    it.maddr  = 12'($urandom_range(0, 4095));
    it.mdata  = 8'($urandom_range(0, 255));
    if (it.op == smfe_pkg::CMD_COPY && $urandom_range(0, 2) == 0)
      it.dst = it.src + 64'($urandom_range(0, 32)) - 64'd16;
    if ($urandom_range(0, 9) == 0)
      it.src = 64'd0 - 64'($urandom_range(1, 64));
    if (it.rep) begin
      pick = $urandom_range(0, 199);
      if (pick == 0) begin
        it.cnt = 64'($urandom_range(1, MAX_CNT));
      end else if (pick < 16) begin
        it.cnt = rand64();
        if (it.cnt <= 64'(MAX_CNT)) it.cnt = 64'(MAX_CNT) + 64'($urandom_range(1, 1000));
      end else if (pick < 26) begin
        it.cnt = 64'($urandom_range(17, 300));
      end else begin
        it.cnt = 64'($urandom_range(0, 16));
      end
    end else begin
      it.cnt = rand64();
    end
    return it;
  endfunction

  // offer one transaction; entered and left at a falling edge
  task automatic send_instr(input instr_t it);
    if (burst_left == 0 && !no_gaps) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left != 0) burst_left--;
    req_if.cmd        = it.op;
    req_if.repeat_on  = it.rep;
    req_if.dir_down   = it.down;
    req_if.elem_bytes = it.size;
    req_if.count_in   = it.cnt;
    req_if.src_ptr    = it.src;
    req_if.dst_ptr    = it.dst;
    req_if.fill_value = it.fill_v;
    req_if.mem_addr   = it.maddr;
    req_if.mem_data   = it.mdata;
    req_if.valid      = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // result receiver: stretches of different stall patterns, one long hold-off
  initial begin
    int unsigned mode;
    int unsigned stretch;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_go) begin
        hold_off_go  = 1'b0;
        rsp_if.ready = 1'b0;
        repeat (400) @(negedge clk_i);
      end
      mode    = $urandom_range(0, 3);
      stretch = $urandom_range(20, 200);
      repeat (stretch) begin
        case (mode)
          0:       rsp_if.ready = 1'b1;
          1:       rsp_if.ready = 1'($urandom_range(0, 1));
          2:       rsp_if.ready = ($urandom_range(0, 3) == 0);
          default: rsp_if.ready = ($urandom_range(0, 3) != 0);
        endcase
        @(negedge clk_i);
      end
    end
  end

  // stimulus and verdict
  initial begin
    instr_t it;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.cmd        = smfe_pkg::CMD_WRITE;
    req_if.repeat_on  = 1'b0;
    req_if.dir_down   = 1'b0;
    req_if.elem_bytes = '0;
    req_if.count_in   = '0;
    req_if.src_ptr    = '0;
    req_if.dst_ptr    = '0;
    req_if.fill_value = '0;
    req_if.mem_addr   = '0;
    req_if.mem_data   = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // first fill covers the whole memory so every later read sees written bytes
    directed_q.push_back(make_instr(smfe_pkg::CMD_FILL, 1'b1, 1'b0, 4'd8, 64'd512,
                                    rand64(), rand64(), rand64(), 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_WRITE, 1'b0, 1'b0, 4'd0, '1, '1, '1,
                                    '1, 12'd0, 8'hFF));
    directed_q.push_back(make_instr(smfe_pkg::CMD_WRITE, 1'b0, 1'b1, 4'd15, '0, '0, '0,
                                    '0, 12'hFFF, 8'h00));
    directed_q.push_back(make_instr(smfe_pkg::CMD_READ, 1'b1, 1'b1, 4'd15, '1, '1, '1,
                                    '1, 12'd0, 8'h00));
    directed_q.push_back(make_instr(smfe_pkg::CMD_READ, 1'b0, 1'b0, 4'd0, '0, '0, '0,
                                    '0, 12'hFFF, 8'hFF));
    // pointer wrap upward and downward
    directed_q.push_back(make_instr(smfe_pkg::CMD_COPY, 1'b0, 1'b0, 4'd1, '1, '1, 64'd0,
                                    '0, 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_COPY, 1'b1, 1'b1, 4'd8, 64'd3, 64'd0,
                                    64'd5, '0, 12'd0, 8'd0));
    // overlapping copies both ways
    directed_q.push_back(make_instr(smfe_pkg::CMD_COPY, 1'b1, 1'b0, 4'd2, 64'd10, 64'd100,
                                    64'd101, '0, 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_COPY, 1'b1, 1'b1, 4'd4, 64'd7, 64'd200,
                                    64'd198, '0, 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_READ, 1'b0, 1'b0, 4'd0, '0, '0, '0, '0,
                                    12'd101, 8'd0));
    // fills with masking of the accumulator
    directed_q.push_back(make_instr(smfe_pkg::CMD_FILL, 1'b0, 1'b0, 4'd1, rand64(),
                                    rand64(), 64'd4095, '1, 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_FILL, 1'b1, 1'b1, 4'd2, 64'd5, rand64(),
                                    64'd3, 64'h1234_5678_9ABC_DEF0, 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_FILL, 1'b0, 1'b1, 4'd4, '0, '0, 64'd40,
                                    64'hFEDC_BA98_7654_3210, 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_READ, 1'b0, 1'b0, 4'd0, '0, '0, '0, '0,
                                    12'd41, 8'd0));
    // count at the limit, one above and the largest value
    directed_q.push_back(make_instr(smfe_pkg::CMD_FILL, 1'b1, 1'b0, 4'd1, 64'(MAX_CNT),
                                    rand64(), rand64(), rand64(), 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_COPY, 1'b1, 1'b0, 4'd4,
                                    64'(MAX_CNT) + 64'd1, rand64(), rand64(), '0,
                                    12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_FILL, 1'b1, 1'b1, 4'd8, '1, rand64(),
                                    rand64(), '1, 12'd0, 8'd0));
    // zero count beats a bad size, a bad size beats a large count
    directed_q.push_back(make_instr(smfe_pkg::CMD_FILL, 1'b1, 1'b0, 4'd3, 64'd0, rand64(),
                                    rand64(), '1, 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_COPY, 1'b1, 1'b1, 4'd8, 64'd0, rand64(),
                                    rand64(), '0, 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_COPY, 1'b0, 1'b0, 4'd0, rand64(),
                                    rand64(), rand64(), '0, 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_FILL, 1'b1, 1'b1, 4'd15, '1, rand64(),
                                    rand64(), '1, 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_COPY, 1'b1, 1'b0, 4'd3, 64'd9, rand64(),
                                    rand64(), '0, 12'd0, 8'd0));
    // longest walks
    directed_q.push_back(make_instr(smfe_pkg::CMD_COPY, 1'b1, 1'b0, 4'd8, 64'(MAX_CNT),
                                    rand64(), rand64(), '0, 12'd0, 8'd0));
    directed_q.push_back(make_instr(smfe_pkg::CMD_FILL, 1'b1, 1'b1, 4'd8, 64'(MAX_CNT),
                                    rand64(), rand64(), rand64(), 12'd0, 8'd0));
    foreach (directed_q[i]) send_instr(directed_q[i]);
    wait_drained();

    // random traffic
    for (int unsigned n = 0; n < RAND_INSTRS; n++) begin
      if (n == 250) begin
        // receiver holds off while back-to-back byte accesses pile up
        hold_off_go = 1'b1;
        no_gaps     = 1'b1;
        repeat (30) begin
          it = random_instr();
          it.op = ($urandom_range(0, 1) != 0) ? smfe_pkg::CMD_WRITE : smfe_pkg::CMD_READ;
          send_instr(it);
        end
        no_gaps = 1'b0;
      end
      if (n == 500) wait_drained();
      send_instr(random_instr());
    end

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("string_move_fill_engine_core test passed");
    end else begin
      $display("string_move_fill_engine_core test failed");
    end
    $finish;
  end

endmodule

>>> string_move_fill_engine_core.f
rtl/core/smfe_pkg.sv
rtl/core/smfe_req_if.sv
rtl/core/smfe_rsp_if.sv
rtl/core/smfe_mem.sv
rtl/core/smfe_seq.sv
rtl/core/string_move_fill_engine_core.sv
dv/smfe_string_checker.sv
dv/tb_string_move_fill_engine_core.sv
